FILE: rtl/pdp11pd_pkg.sv
// Types, mnemonic codes and the operand helper shared by the instruction predecoder.
package pdp11pd_pkg;

    localparam logic [5:0] MN_HALT       = 6'd0;
    localparam logic [5:0] MN_RTI        = 6'd1;
    localparam logic [5:0] MN_NOP        = 6'd2;
    localparam logic [5:0] MN_CLC        = 6'd3;
    localparam logic [5:0] MN_CLV        = 6'd4;
    localparam logic [5:0] MN_CLZ        = 6'd5;
    localparam logic [5:0] MN_CLN        = 6'd6;
    localparam logic [5:0] MN_CCC        = 6'd7;
    localparam logic [5:0] MN_SEC        = 6'd8;
    localparam logic [5:0] MN_SEV        = 6'd9;
    localparam logic [5:0] MN_SEZ        = 6'd10;
    localparam logic [5:0] MN_SEN        = 6'd11;
    localparam logic [5:0] MN_SCC        = 6'd12;
    localparam logic [5:0] MN_FLAG_OTHER = 6'd13;
    localparam logic [5:0] MN_RTS        = 6'd14;
    localparam logic [5:0] MN_MOV        = 6'd15;
    localparam logic [5:0] MN_CMP        = 6'd16;
    localparam logic [5:0] MN_BIT        = 6'd17;
    localparam logic [5:0] MN_BIC        = 6'd18;
    localparam logic [5:0] MN_BIS        = 6'd19;
    localparam logic [5:0] MN_ADD        = 6'd20;
    localparam logic [5:0] MN_SUB        = 6'd21;
    localparam logic [5:0] MN_JMP        = 6'd22;
    localparam logic [5:0] MN_SWAB       = 6'd23;
    localparam logic [5:0] MN_CLR        = 6'd24;
    localparam logic [5:0] MN_SOB        = 6'd36;
    localparam logic [5:0] MN_JSR        = 6'd37;
    localparam logic [5:0] MN_BR         = 6'd38;
    localparam logic [5:0] MN_BPL        = 6'd45;
    localparam logic [5:0] MN_EMT        = 6'd53;
    localparam logic [5:0] MN_TRAP       = 6'd54;
    localparam logic [5:0] MN_UNKNOWN    = 6'd55;

    localparam logic [2:0] MODE_AUTOINC     = 3'd2;
    localparam logic [2:0] MODE_AUTOINC_DEF = 3'd3;
    localparam logic [2:0] MODE_INDEX       = 3'd6;
    localparam logic [2:0] MODE_INDEX_DEF   = 3'd7;
    localparam logic [2:0] REG_PC           = 3'd7;

    typedef struct packed {
        logic [15:0] instr_word;
        logic [15:0] instr_addr;
        logic [15:0] next_word_a;
        logic [15:0] next_word_b;
    } instr_item_t;

    typedef struct packed {
        logic [5:0]  mnemonic;
        logic [2:0]  length_bytes;
        logic [1:0]  operand_count;
        logic [2:0]  src_mode;
        logic [2:0]  src_reg;
        logic [2:0]  dst_mode;
        logic [2:0]  dst_reg;
        logic [15:0] src_value;
        logic [15:0] dst_value;
        logic [2:0]  link_reg;
        logic [15:0] aux_value;
    } dec_rec_t;

    typedef struct packed {
        logic        ext;
        logic [15:0] value;
    } opnd_t;

    function automatic opnd_t operand_value(input logic [2:0] mode, input logic [2:0] rnum,
                                            input logic [15:0] ext_addr,
                                            input logic [15:0] word);
        opnd_t res;
        res = '0;
        if (mode == MODE_AUTOINC || mode == MODE_AUTOINC_DEF) begin
            if (rnum == REG_PC) begin
                res.ext   = 1'b1;
                res.value = word;
            end
        end
        else if (mode == MODE_INDEX || mode == MODE_INDEX_DEF) begin
            res.ext = 1'b1;
            if (rnum == REG_PC) begin
                res.value = ext_addr + 16'd2 + word;
            end
            else begin
                res.value = word;
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/pdp11pd_decode.sv
// Combinational decode of one registered instruction into its result record.
module pdp11pd_decode
    import pdp11pd_pkg::*;
(
    input  instr_item_t item,
    output dec_rec_t    rec
);

    logic [15:0] w;
    logic [15:0] addr;
    logic [15:0] pc_next;
    logic [9:0]  one_op;
    logic [7:0]  hi;
    logic        two_hit;
    logic [5:0]  two_mn;
    logic        one_hit;
    logic [5:0]  one_mn;
    logic        br_hit;
    logic [5:0]  br_mn;
    logic [15:0] dst_addr;
    opnd_t       src_op;
    opnd_t       dst_op;
    opnd_t       single_op;

    assign w       = item.instr_word;
    assign addr    = item.instr_addr;
    assign pc_next = addr + 16'd2;
    assign one_op  = w[15:6];
    assign hi      = w[15:8];

    always_comb
    begin
        two_hit = 1'b1;
        two_mn  = MN_MOV;
        case (w[15:12])
            4'o1:    two_mn = MN_MOV;
            4'o2:    two_mn = MN_CMP;
            4'o3:    two_mn = MN_BIT;
            4'o4:    two_mn = MN_BIC;
            4'o5:    two_mn = MN_BIS;
            4'o6:    two_mn = MN_ADD;
            4'hE:    two_mn = MN_SUB;
            default: two_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        one_hit = 1'b1;
        one_mn  = MN_JMP;
        if (one_op == 10'o1) begin
            one_mn = MN_JMP;
        end
        else if (one_op == 10'o3) begin
            one_mn = MN_SWAB;
        end
        else if (one_op >= 10'o50 && one_op <= 10'o63) begin
            one_mn = MN_CLR + 6'(one_op - 10'o50);
        end
        else begin
            one_hit = 1'b0;
        end
    end

    always_comb
    begin
        br_hit = 1'b1;
        br_mn  = MN_BR;
        if (hi >= 8'o1 && hi <= 8'o7) begin
            br_mn = MN_BR + 6'(hi - 8'o1);
        end
        else if (hi >= 8'o200 && hi <= 8'o207) begin
            br_mn = MN_BPL + 6'(hi - 8'o200);
        end
        else begin
            br_hit = 1'b0;
        end
    end

    assign src_op    = operand_value(w[11:9], w[8:6], pc_next, item.next_word_a);
    assign dst_addr  = pc_next + (src_op.ext ? 16'd2 : 16'd0);
    assign dst_op    = operand_value(w[5:3], w[2:0], dst_addr,
                                     src_op.ext ? item.next_word_b : item.next_word_a);
    assign single_op = operand_value(w[5:3], w[2:0], pc_next, item.next_word_a);

    always_comb
    begin
        rec = '0;
        rec.length_bytes = 3'd2;
        if (w == 16'o0) begin
            rec.mnemonic = MN_HALT;
        end
        else if (w == 16'o2) begin
            rec.mnemonic = MN_RTI;
        end
        else if (w >= 16'o240 && w <= 16'o277) begin
            case (w[5:0])
                6'o40: rec.mnemonic = MN_NOP;
                6'o41: rec.mnemonic = MN_CLC;
                6'o42: rec.mnemonic = MN_CLV;
                6'o44: rec.mnemonic = MN_CLZ;
                6'o50: rec.mnemonic = MN_CLN;
                6'o57: rec.mnemonic = MN_CCC;
                6'o61: rec.mnemonic = MN_SEC;
                6'o62: rec.mnemonic = MN_SEV;
                6'o64: rec.mnemonic = MN_SEZ;
                6'o70: rec.mnemonic = MN_SEN;
                6'o77: rec.mnemonic = MN_SCC;
                default:
                begin
                    rec.mnemonic  = MN_FLAG_OTHER;
                    rec.aux_value = w;
                end
            endcase
        end
        else if ((w & 16'hFFF8) == 16'o200) begin
            rec.mnemonic = MN_RTS;
            rec.link_reg = w[2:0];
        end
        else if (two_hit) begin
            rec.mnemonic      = two_mn;
            rec.length_bytes  = 3'd2 + {1'b0, src_op.ext, 1'b0} + {1'b0, dst_op.ext, 1'b0};
            rec.operand_count = 2'd2;
            rec.src_mode      = w[11:9];
            rec.src_reg       = w[8:6];
            rec.dst_mode      = w[5:3];
            rec.dst_reg       = w[2:0];
            rec.src_value     = src_op.value;
            rec.dst_value     = dst_op.value;
        end
        else if (one_hit || (w & 16'hFE00) == 16'h0800) begin
            if (one_hit) begin
                rec.mnemonic = one_mn;
            end
            else begin
                rec.mnemonic = MN_JSR;
                rec.link_reg = w[8:6];
            end
            rec.length_bytes  = 3'd2 + {1'b0, single_op.ext, 1'b0};
            rec.operand_count = 2'd1;
            rec.dst_mode      = w[5:3];
            rec.dst_reg       = w[2:0];
            rec.dst_value     = single_op.value;
        end
        else if (w[15:9] == 7'o77) begin
            rec.mnemonic  = MN_SOB;
            rec.link_reg  = w[8:6];
            rec.aux_value = pc_next - {9'd0, w[5:0], 1'b0};
        end
        else if (br_hit) begin
            rec.mnemonic  = br_mn;
            rec.aux_value = pc_next + {{7{w[7]}}, w[7:0], 1'b0};
        end
        else if (hi == 8'o210) begin
            rec.mnemonic  = MN_EMT;
            rec.aux_value = {8'd0, w[7:0]};
        end
        else if (hi == 8'o211) begin
            rec.mnemonic  = MN_TRAP;
            rec.aux_value = {8'd0, w[7:0]};
        end
        else begin
            rec.mnemonic  = MN_UNKNOWN;
            rec.aux_value = w;
        end
    end

endmodule

FILE: rtl/pdp11_instruction_predecoder.sv
// Top level of the instruction predecoder: input register, decode and result register.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_stall   instr_word, instr_addr, next_word_a, next_word_b
//   output    out_valid / out_stall mnemonic .. aux_value (one record per transaction)
//
// Each transaction is decoded in a single pass between the input and result registers,
// so a new transaction is accepted every cycle while in_stall is low.
// Reset clears both valid flags; no stored state carries between transactions.
// A stall on a valid output holds the result register and, once the input register is also
// full, raises in_stall in the same cycle.
module pdp11_instruction_predecoder
    import pdp11pd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] instr_word,
    input  logic [15:0] instr_addr,
    input  logic [15:0] next_word_a,
    input  logic [15:0] next_word_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  mnemonic,
    output logic [2:0]  length_bytes,
    output logic [1:0]  operand_count,
    output logic [2:0]  src_mode,
    output logic [2:0]  src_reg,
    output logic [2:0]  dst_mode,
    output logic [2:0]  dst_reg,
    output logic [15:0] src_value,
    output logic [15:0] dst_value,
    output logic [2:0]  link_reg,
    output logic [15:0] aux_value
);

    instr_item_t item_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    dec_rec_t    rec_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    dec_rec_t    dec_rec;
    logic        out_adv;
    logic        in_load;

    pdp11pd_decode u_decode
    (
        .item (item_reg),
        .rec  (dec_rec)
    );

    assign out_adv        = !out_valid_reg || !out_stall;
    assign in_stall       = in_valid_reg && !out_adv;
    assign in_load        = in_valid && !in_stall;
    assign in_valid_next  = in_load || (in_valid_reg && !out_adv);
    assign out_valid_next = out_adv ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load) begin
            item_reg.instr_word  <= instr_word;
            item_reg.instr_addr  <= instr_addr;
            item_reg.next_word_a <= next_word_a;
            item_reg.next_word_b <= next_word_b;
        end
        if (out_adv && in_valid_reg) begin
            rec_reg <= dec_rec;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mnemonic      = rec_reg.mnemonic;
    assign length_bytes  = rec_reg.length_bytes;
    assign operand_count = rec_reg.operand_count;
    assign src_mode      = rec_reg.src_mode;
    assign src_reg       = rec_reg.src_reg;
    assign dst_mode      = rec_reg.dst_mode;
    assign dst_reg       = rec_reg.dst_reg;
    assign src_value     = rec_reg.src_value;
    assign dst_value     = rec_reg.dst_value;
    assign link_reg      = rec_reg.link_reg;
    assign aux_value     = rec_reg.aux_value;

endmodule
